>>> rtl/grt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package grt_pkg;

   // default sizes
   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int PROP_RANGE_FAST = 512;
   localparam int PIXEL_BITS_DEF  = 24;

   // fixed field widths
   localparam int WIDTH_BITS     = 13;
   localparam int HEIGHT_BITS    = 16;
   localparam int MODE_BITS      = 2;
   localparam int CONTEXT_BITS   = 16;
   localparam int INDEX_BITS     = 10;
   localparam int OFFSET_BITS    = 8;
   localparam int SYMBOL_BITS    = 26;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // result queue
   localparam int OUT_FIFO_DEPTH = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_PREDICT_MODE  = 2'd2,
      REG_FIXED_CONTEXT = 2'd3
   } csr_index_type;

   localparam logic [MODE_BITS-1:0] MODE_GRAD_FIXED = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_GRAD_TABLE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_ZERO       = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_TABLE = 1'b1;

   typedef struct packed {
      logic [CONTEXT_BITS-1:0] ctx_id;
      logic [SYMBOL_BITS-1:0]  symbol;
      logic                    chan_end;
   } token_type;

endpackage

`default_nettype wire

>>> rtl/grt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module grt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write to one address return the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/gradient_residual_tokenizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// path: pixel results pass the stage 1 and stage 2 registers into the result queue
// throughput: one transaction per cycle; the row store and context table each take
// one write and one read per cycle, and four results queued or in flight stall input
// reset: synchronous, restores register defaults and clears raster position and queue;
// row store and context table are not cleared and must be written before use

module gradient_residual_tokenizer_unit #(
   parameter int MAX_WIDTH  = grt_pkg::MAX_WIDTH_DEF,
   parameter int PROP_RANGE = grt_pkg::PROP_RANGE_FAST,
   parameter int PIXEL_BITS = grt_pkg::PIXEL_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [grt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [grt_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic signed [PIXEL_BITS-1:0]         req_pixel_value,
   input  logic [grt_pkg::INDEX_BITS-1:0]       req_table_index,
   input  logic [grt_pkg::CONTEXT_BITS-1:0]     req_table_context,
   input  logic signed [grt_pkg::OFFSET_BITS-1:0] req_table_offset,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [grt_pkg::CONTEXT_BITS-1:0]     rsp_token_context,
   output logic [grt_pkg::SYMBOL_BITS-1:0]      rsp_token_symbol,
   output logic                                 rsp_channel_end
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WCW = (XW + 1 > grt_pkg::WIDTH_BITS) ? XW + 1 : grt_pkg::WIDTH_BITS;
   localparam int HCW = grt_pkg::HEIGHT_BITS + 1;
   localparam int TABLE_SIZE = 2 * PROP_RANGE;
   localparam int TW = $clog2(TABLE_SIZE);
   localparam int TIW = (TW + 1 > grt_pkg::INDEX_BITS) ? TW + 1 : grt_pkg::INDEX_BITS;
   localparam int GW = PIXEL_BITS + 2;
   localparam int CGW = (GW > TW + 2) ? GW : TW + 2;
   localparam int RW = PIXEL_BITS + 2;
   localparam int ZW = (RW > grt_pkg::SYMBOL_BITS) ? RW : grt_pkg::SYMBOL_BITS;
   localparam int TBL_BITS = grt_pkg::CONTEXT_BITS + grt_pkg::OFFSET_BITS;
   localparam int FD = grt_pkg::OUT_FIFO_DEPTH;
   localparam int FPW = $clog2(FD);
   localparam int FCW = $clog2(FD + 3);
   localparam logic signed [CGW-1:0] G_LO = CGW'(-PROP_RANGE);
   localparam logic signed [CGW-1:0] G_HI = CGW'(PROP_RANGE - 1);
   localparam logic signed [CGW-1:0] G_BIAS = CGW'(PROP_RANGE);

   // configuration registers
   logic [grt_pkg::WIDTH_BITS-1:0]   image_width_ff;
   logic [grt_pkg::HEIGHT_BITS-1:0]  image_height_ff;
   logic [grt_pkg::MODE_BITS-1:0]    predict_mode_ff;
   logic [grt_pkg::CONTEXT_BITS-1:0] fixed_context_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= grt_pkg::WIDTH_BITS'(1);
         image_height_ff  <= grt_pkg::HEIGHT_BITS'(1);
         predict_mode_ff  <= grt_pkg::MODE_GRAD_FIXED;
         fixed_context_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            grt_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data[grt_pkg::WIDTH_BITS-1:0];
            end
            grt_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data[grt_pkg::HEIGHT_BITS-1:0];
            end
            grt_pkg::REG_PREDICT_MODE: begin
               predict_mode_ff <= csr_write_data[grt_pkg::MODE_BITS-1:0];
            end
            grt_pkg::REG_FIXED_CONTEXT: begin
               fixed_context_ff <= csr_write_data[grt_pkg::CONTEXT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- accept stage: raster position and memory access
   logic [XW-1:0]  col_ff, col_in, col_x;
   logic [grt_pkg::HEIGHT_BITS-1:0] row_ff, row_in;
   logic [WCW-1:0] width_eff;
   logic [HCW-1:0] height_eff;
   logic           last_col, last_row;
   logic           accept, pix_accept, tbl_accept;

   assign accept     = req_valid && !req_stall;
   assign pix_accept = accept && (req_cmd == grt_pkg::CMD_PIXEL);
   assign tbl_accept = accept && (req_cmd == grt_pkg::CMD_TABLE)
                       && (TIW'(req_table_index) < TIW'(TABLE_SIZE));

   always_comb begin
      width_eff = WCW'(image_width_ff);
      if (image_width_ff == '0) begin
         width_eff = WCW'(1);
      end
      if (width_eff > WCW'(MAX_WIDTH)) begin
         width_eff = WCW'(MAX_WIDTH);
      end
      height_eff = HCW'(image_height_ff);
      if (image_height_ff == '0) begin
         height_eff = HCW'(1);
      end
   end

   always_comb begin
      col_x = col_ff;
      if (WCW'(col_ff) >= width_eff) begin
         col_x = XW'(width_eff - WCW'(1));
      end
      last_col = (WCW'(col_x) + WCW'(1)) >= width_eff;
      last_row = (HCW'(row_ff) + HCW'(1)) >= height_eff;
      col_in = col_ff;
      row_in = row_ff;
      if (pix_accept) begin
         if (!last_col) begin
            col_in = col_x + XW'(1);
         end else begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + grt_pkg::HEIGHT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // row store: the old word at this column is the sample above
   logic [PIXEL_BITS-1:0] row_rd_data;

   grt_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (pix_accept),
      .wr_addr (col_x),
      .wr_data (req_pixel_value),
      .rd_addr (col_x),
      .rd_data (row_rd_data)
   );

   logic                            s1_valid_ff;
   logic signed [PIXEL_BITS-1:0]    s1_pix_ff;
   logic                            s1_xnz_ff, s1_ynz_ff, s1_end_ff;
   logic [grt_pkg::MODE_BITS-1:0]   s1_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pix_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff  <= req_pixel_value;
      s1_xnz_ff  <= (col_x != '0);
      s1_ynz_ff  <= (row_ff != '0);
      s1_end_ff  <= last_col && last_row;
      s1_mode_ff <= predict_mode_ff;
   end

   // ---------------- stage 1: neighbours, prediction, table address
   logic signed [PIXEL_BITS-1:0] left_ff, tl_ff;
   logic signed [PIXEL_BITS-1:0] top_raw, left_s1, top_s1, tl_s1, lo_s1, hi_s1, guess_s1;
   logic signed [GW-1:0]         grad_s1;
   logic signed [CGW-1:0]        grad_c, pos_wide;
   logic signed [PIXEL_BITS:0]   resid_s1;
   logic [TW-1:0]                tbl_rd_addr;
   logic                         grad_mode;

   assign top_raw   = row_rd_data;
   assign grad_mode = (s1_mode_ff == grt_pkg::MODE_GRAD_FIXED)
                      || (s1_mode_ff == grt_pkg::MODE_GRAD_TABLE);

   always_comb begin
      // edges: column 0 takes the sample above, row 0 has top equal to left
      left_s1 = s1_xnz_ff ? left_ff : (s1_ynz_ff ? top_raw : '0);
      top_s1  = s1_ynz_ff ? top_raw : left_s1;
      tl_s1   = (s1_xnz_ff && s1_ynz_ff) ? tl_ff : left_s1;
      lo_s1   = (top_s1 < left_s1) ? top_s1 : left_s1;
      hi_s1   = (top_s1 < left_s1) ? left_s1 : top_s1;
      grad_s1 = GW'(top_s1) + GW'(left_s1) - GW'(tl_s1);
      if (tl_s1 < lo_s1) begin
         guess_s1 = hi_s1;
      end else if (tl_s1 > hi_s1) begin
         guess_s1 = lo_s1;
      end else begin
         guess_s1 = PIXEL_BITS'(grad_s1);
      end
      if (grad_mode) begin
         resid_s1 = (PIXEL_BITS + 1)'(s1_pix_ff) - (PIXEL_BITS + 1)'(guess_s1);
      end else begin
         resid_s1 = (PIXEL_BITS + 1)'(s1_pix_ff);
      end
      grad_c = CGW'(grad_s1);
      if (grad_c < G_LO) begin
         grad_c = G_LO;
      end else if (grad_c > G_HI) begin
         grad_c = G_HI;
      end
      pos_wide    = grad_c + G_BIAS;
      tbl_rd_addr = pos_wide[TW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         tl_ff   <= '0;
      end else if (s1_valid_ff) begin
         left_ff <= s1_pix_ff;
         tl_ff   <= top_s1;
      end
   end

   logic [TBL_BITS-1:0] tbl_rd_data;

   grt_ram #(
      .WIDTH (TBL_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_context_table (
      .clock   (clock),
      .wr_en   (tbl_accept),
      .wr_addr (TW'(req_table_index)),
      .wr_data ({req_table_context, req_table_offset}),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   logic                      s2_valid_ff;
   logic signed [PIXEL_BITS:0] s2_resid_ff;
   logic                      s2_end_ff, s2_table_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_resid_ff <= resid_s1;
      s2_end_ff   <= s1_end_ff;
      s2_table_ff <= (s1_mode_ff == grt_pkg::MODE_GRAD_TABLE);
   end

   // ---------------- stage 2: table offset, zigzag
   logic signed [grt_pkg::OFFSET_BITS-1:0] tbl_off;
   logic signed [RW-1:0]     off_term, resid_s2;
   logic [RW-1:0]            zz_s2;
   logic [ZW-1:0]            zz_ext;
   grt_pkg::token_type       token_s2;

   assign tbl_off = tbl_rd_data[grt_pkg::OFFSET_BITS-1:0];

   always_comb begin
      off_term = '0;
      if (s2_table_ff) begin
         off_term = RW'(tbl_off);
      end
      resid_s2 = RW'(s2_resid_ff) - off_term;
      zz_s2    = {resid_s2[RW-2:0], 1'b0} ^ {RW{resid_s2[RW-1]}};
      zz_ext   = ZW'(zz_s2);
      token_s2.ctx_id   = s2_table_ff ? tbl_rd_data[TBL_BITS-1:grt_pkg::OFFSET_BITS]
                                      : fixed_context_ff;
      token_s2.symbol   = zz_ext[grt_pkg::SYMBOL_BITS-1:0];
      token_s2.chan_end = s2_end_ff;
   end

   // ---------------- result queue, sized to cover everything in flight
   grt_pkg::token_type fifo_mem_ff [FD];
   logic [FPW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FCW-1:0]     count_ff, count_in, credit;
   logic               push, pop;

   assign push = s2_valid_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FPW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= token_s2;
      end
   end

   assign credit    = count_ff + FCW'(s1_valid_ff) + FCW'(s2_valid_ff);
   assign req_stall = credit >= FCW'(FD);

   assign rsp_valid         = (count_ff != '0);
   assign rsp_token_context = fifo_mem_ff[rd_ptr_ff].ctx_id;
   assign rsp_token_symbol  = fifo_mem_ff[rd_ptr_ff].symbol;
   assign rsp_channel_end   = fifo_mem_ff[rd_ptr_ff].chan_end;

   // ---------------- checks
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == FCW'(FD))))
      else $error("result queue overflow");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit <= FCW'(FD))
      else $error("more results in flight than queue entries");

   a_channel_wrap: assert property (@(posedge clock) disable iff (reset)
      (pix_accept && last_col && last_row) |=> (col_ff == '0) && (row_ff == '0))
      else $error("raster position not cleared after channel end");

endmodule

`default_nettype wire

>>> verif/gradient_residual_tokenizer_unit_test.sv
`timescale 1ns / 1ps

module gradient_residual_tokenizer_unit_test;

   localparam int ROW_DEPTH     = grt_pkg::MAX_WIDTH_DEF;
   localparam int SLOT_COUNT    = 2 * grt_pkg::PROP_RANGE_FAST;
   localparam int PX_BITS       = grt_pkg::PIXEL_BITS_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [grt_pkg::MODE_BITS-1:0] MODE_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [grt_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [grt_pkg::CSR_DATA_BITS-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = grt_pkg::CMD_PIXEL;
   logic signed [PX_BITS-1:0] req_pixel_value = '0;
   logic [grt_pkg::INDEX_BITS-1:0] req_table_index = '0;
   logic [grt_pkg::CONTEXT_BITS-1:0] req_table_context = '0;
   logic signed [grt_pkg::OFFSET_BITS-1:0] req_table_offset = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [grt_pkg::CONTEXT_BITS-1:0] rsp_token_context;
   logic [grt_pkg::SYMBOL_BITS-1:0] rsp_token_symbol;
   logic rsp_channel_end;

   // predictor copy of registers and raster state
   logic [grt_pkg::WIDTH_BITS-1:0] width_reg = grt_pkg::WIDTH_BITS'(1);
   logic [grt_pkg::HEIGHT_BITS-1:0] height_reg = grt_pkg::HEIGHT_BITS'(1);
   logic [grt_pkg::MODE_BITS-1:0] mode_reg = grt_pkg::MODE_GRAD_FIXED;
   logic [grt_pkg::CONTEXT_BITS-1:0] fixed_ctx_reg = '0;
   logic signed [PX_BITS-1:0] prev_row [ROW_DEPTH];
   logic signed [PX_BITS-1:0] left_px = '0;
   logic signed [PX_BITS-1:0] topleft_px = '0;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   logic [grt_pkg::CONTEXT_BITS-1:0] slot_ctx [SLOT_COUNT];
   logic signed [grt_pkg::OFFSET_BITS-1:0] slot_offset [SLOT_COUNT];
   bit slot_loaded [SLOT_COUNT];

   grt_pkg::token_type pending_tokens [$];
   int mismatches = 0;
   int cycle_count = 0;
   int req_idle_pct = 12;
   int rsp_stall_pct = 12;
   int hold_off_cycles = 0;

   gradient_residual_tokenizer_unit dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned row_length();
      int unsigned w;
      w = (width_reg == 0) ? 1 : width_reg;
      return (w > ROW_DEPTH) ? ROW_DEPTH : w;
   endfunction

   function automatic int unsigned column_now();
      return (col_pos >= row_length()) ? row_length() - 1 : col_pos;
   endfunction

   // edge substitutions: left from the row above at column 0, top and topleft fall back to left
   function automatic void fetch_neighbours(output int left, output int top, output int tl);
      int unsigned x;
      x = column_now();
      if (x > 0) left = left_px;
      else if (row_pos > 0) left = prev_row[0];
      else left = 0;
      top = (row_pos > 0) ? prev_row[x] : left;
      tl = (x > 0 && row_pos > 0) ? topleft_px : left;
   endfunction

   function automatic int unsigned context_slot();
      int left, top, tl, g;
      fetch_neighbours(left, top, tl);
      g = top + left - tl;
      if (g < -grt_pkg::PROP_RANGE_FAST) g = -grt_pkg::PROP_RANGE_FAST;
      if (g > grt_pkg::PROP_RANGE_FAST - 1) g = grt_pkg::PROP_RANGE_FAST - 1;
      return unsigned'(g + grt_pkg::PROP_RANGE_FAST);
   endfunction

   function automatic void tokenize_pixel(input logic signed [PX_BITS-1:0] px);
      int unsigned x, w, h, slot;
      int left, top, tl, lo, hi, guess;
      longint resid;
      grt_pkg::token_type tok;
      w = row_length();
      h = (height_reg == 0) ? 1 : height_reg;
      x = column_now();
      fetch_neighbours(left, top, tl);
      tok.ctx_id = fixed_ctx_reg;
      if (mode_reg == grt_pkg::MODE_GRAD_FIXED || mode_reg == grt_pkg::MODE_GRAD_TABLE) begin
         lo = (top < left) ? top : left;
         hi = (top < left) ? left : top;
         if (tl < lo) guess = hi;
         else if (tl > hi) guess = lo;
         else guess = top + left - tl;
         resid = longint'(px) - guess;
         if (mode_reg == grt_pkg::MODE_GRAD_TABLE) begin
            slot = context_slot();
            tok.ctx_id = slot_ctx[slot];
            resid -= slot_offset[slot];
         end
      end else begin
         resid = px;
      end
      tok.symbol = (resid >= 0) ? grt_pkg::SYMBOL_BITS'(resid << 1)
                                : grt_pkg::SYMBOL_BITS'(((-(resid + 1)) << 1) | 1);
      tok.chan_end = (x + 1 >= w) && (row_pos + 1 >= h);
      topleft_px = PX_BITS'(top);
      left_px = px;
      prev_row[x] = px;
      if (x + 1 < w) begin
         col_pos = x + 1;
      end else begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end
      pending_tokens.push_back(tok);
   endfunction

   function automatic logic signed [PX_BITS-1:0] random_pixel();
      logic signed [PX_BITS-1:0] px_max;
      px_max = {1'b0, {(PX_BITS-1){1'b1}}};
      case ($urandom_range(9))
         0: return $urandom_range(1) ? px_max : ~px_max;
         1, 2, 3, 4: return PX_BITS'($urandom_range(1200) - 600);
         default: return PX_BITS'($urandom);
      endcase
   endfunction

   task automatic push_item(input logic cmd, input logic signed [PX_BITS-1:0] px,
                            input int unsigned idx, input int unsigned tctx,
                            input int toff);
      logic [grt_pkg::INDEX_BITS-1:0] idx_bits;
      logic [grt_pkg::CONTEXT_BITS-1:0] ctx_bits;
      logic signed [grt_pkg::OFFSET_BITS-1:0] off_bits;
      idx_bits = grt_pkg::INDEX_BITS'(idx);
      ctx_bits = grt_pkg::CONTEXT_BITS'(tctx);
      off_bits = grt_pkg::OFFSET_BITS'(toff);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_pixel_value <= px;
      req_table_index <= idx_bits;
      req_table_context <= ctx_bits;
      req_table_offset <= off_bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == grt_pkg::CMD_TABLE) begin
         slot_ctx[idx_bits] = ctx_bits;
         slot_offset[idx_bits] = off_bits;
         slot_loaded[idx_bits] = 1'b1;
      end else begin
         tokenize_pixel(px);
      end
   endtask

   // in table mode an unloaded slot gets filled before the pixel that reads it
   task automatic send_pixel(input logic signed [PX_BITS-1:0] px);
      int unsigned slot;
      if (mode_reg == grt_pkg::MODE_GRAD_TABLE) begin
         slot = context_slot();
         if (!slot_loaded[slot]) begin
            push_item(grt_pkg::CMD_TABLE, random_pixel(), slot, $urandom, $urandom);
         end
      end
      push_item(grt_pkg::CMD_PIXEL, px, $urandom, $urandom, $urandom);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input grt_pkg::csr_index_type idx, input int unsigned data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= grt_pkg::CSR_DATA_BITS'(data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         grt_pkg::REG_IMAGE_WIDTH: width_reg = grt_pkg::WIDTH_BITS'(data);
         grt_pkg::REG_IMAGE_HEIGHT: height_reg = grt_pkg::HEIGHT_BITS'(data);
         grt_pkg::REG_PREDICT_MODE: mode_reg = grt_pkg::MODE_BITS'(data);
         grt_pkg::REG_FIXED_CONTEXT: fixed_ctx_reg = grt_pkg::CONTEXT_BITS'(data);
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      int unsigned new_len;
      new_len = (w == 0) ? 1 : ((w > ROW_DEPTH) ? ROW_DEPTH : w);
      settle_block();
      if (new_len > row_length() && (col_pos != 0 || row_pos != 0)) begin
         // widening mid-channel would read row store columns never written, so end the channel
         write_csr(grt_pkg::REG_IMAGE_HEIGHT, 1);
         while (col_pos != 0 || row_pos != 0) send_pixel(random_pixel());
         settle_block();
      end
      write_csr(grt_pkg::REG_IMAGE_WIDTH, w);
      write_csr(grt_pkg::REG_IMAGE_HEIGHT, h);
   endtask

   task automatic test_gradient_edges();
      logic signed [PX_BITS-1:0] px_max, px_min;
      logic signed [PX_BITS-1:0] samples [12];
      px_max = {1'b0, {(PX_BITS-1){1'b1}}};
      px_min = ~px_max;
      samples = '{px_max, px_min, PX_BITS'(0), PX_BITS'(-1), px_min, px_max,
                  PX_BITS'(1), px_max, PX_BITS'(0), px_min, PX_BITS'(-1), PX_BITS'(5)};
      settle_block();
      write_csr(grt_pkg::REG_PREDICT_MODE, grt_pkg::MODE_GRAD_FIXED);
      write_csr(grt_pkg::REG_FIXED_CONTEXT, 16'hFFFF);
      set_geometry(4, 3);
      foreach (samples[i]) send_pixel(samples[i]);
   endtask

   task automatic test_mode_select();
      settle_block();
      write_csr(grt_pkg::REG_PREDICT_MODE, grt_pkg::MODE_ZERO);
      write_csr(grt_pkg::REG_FIXED_CONTEXT, 16'h0000);
      // zero width and height both count as one
      set_geometry(0, 0);
      send_pixel({1'b0, {(PX_BITS-1){1'b1}}});
      send_pixel({1'b1, {(PX_BITS-1){1'b0}}});
      send_pixel(PX_BITS'(-1));
      settle_block();
      write_csr(grt_pkg::REG_PREDICT_MODE, MODE_SPARE);
      write_csr(grt_pkg::REG_FIXED_CONTEXT, 16'h5AA5);
      send_pixel(PX_BITS'(-2));
      send_pixel(PX_BITS'(7));
      send_pixel(random_pixel());
   endtask

   task automatic test_table_context();
      settle_block();
      write_csr(grt_pkg::REG_PREDICT_MODE, grt_pkg::MODE_GRAD_TABLE);
      set_geometry(3, 2);
      push_item(grt_pkg::CMD_TABLE, random_pixel(), 0, 16'h0000, -128);
      push_item(grt_pkg::CMD_TABLE, random_pixel(), SLOT_COUNT - 1, 16'hFFFF, 127);
      push_item(grt_pkg::CMD_TABLE, random_pixel(), grt_pkg::PROP_RANGE_FAST, 16'h1234, 0);
      send_pixel(PX_BITS'(0));
      send_pixel(PX_BITS'(700));
      send_pixel(PX_BITS'(-700));
      send_pixel(PX_BITS'(5));
      send_pixel({1'b0, {(PX_BITS-1){1'b1}}});
      send_pixel({1'b1, {(PX_BITS-1){1'b0}}});
   endtask

   task automatic test_geometry_extremes();
      settle_block();
      write_csr(grt_pkg::REG_PREDICT_MODE, grt_pkg::MODE_GRAD_FIXED);
      write_csr(grt_pkg::REG_FIXED_CONTEXT, $urandom);
      // oversize width counts as the full row store
      set_geometry(13'h1FFF, 1);
      repeat (12) send_pixel(random_pixel());
      set_geometry(1, 16'hFFFF);
      repeat (20) send_pixel(random_pixel());
      set_geometry(8, 4);
      repeat (13) send_pixel(random_pixel());
      // narrowing mid-row leaves the column count beyond the last column
      set_geometry(3, 4);
      repeat (4) send_pixel(random_pixel());
      set_geometry(3, 1);
      repeat (5) send_pixel(random_pixel());
   endtask

   task automatic test_backpressure();
      settle_block();
      write_csr(grt_pkg::REG_PREDICT_MODE, grt_pkg::MODE_GRAD_FIXED);
      set_geometry(6, 5);
      hold_off_cycles = 150;
      repeat (40) send_pixel(random_pixel());
   endtask

   task automatic test_random_streams();
      for (int phase = 0; phase < 8; phase++) begin
         settle_block();
         write_csr(grt_pkg::REG_PREDICT_MODE, phase % 4);
         write_csr(grt_pkg::REG_FIXED_CONTEXT, $urandom);
         set_geometry(($urandom_range(3) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1),
                      $urandom_range(6, 1));
         if (phase == 3) begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         for (int n = 0; n < 30; n++) begin
            if ($urandom_range(9) == 0) begin
               push_item(grt_pkg::CMD_TABLE, random_pixel(), $urandom, $urandom, $urandom);
            end else begin
               send_pixel(random_pixel());
            end
         end
         req_idle_pct = 12;
         rsp_stall_pct = 12;
      end
   endtask

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // each accepted token transaction is matched against the oldest prediction
   always @(posedge clock) begin
      grt_pkg::token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token, actual context %h symbol %h end %b", $time,
                     rsp_token_context, rsp_token_symbol, rsp_channel_end);
            mismatches++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_token_context !== want.ctx_id) begin
               $display("%0t: token_context expected %h actual %h", $time, want.ctx_id,
                        rsp_token_context);
               mismatches++;
            end
            if (rsp_token_symbol !== want.symbol) begin
               $display("%0t: token_symbol expected %h actual %h", $time, want.symbol,
                        rsp_token_symbol);
               mismatches++;
            end
            if (rsp_channel_end !== want.chan_end) begin
               $display("%0t: channel_end expected %b actual %b", $time, want.chan_end,
                        rsp_channel_end);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("gradient_residual_tokenizer_unit: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_gradient_edges();
      test_mode_select();
      test_table_context();
      test_geometry_extremes();
      test_backpressure();
      test_random_streams();
      settle_block();
      if (mismatches == 0 && pending_tokens.size() == 0) begin
         $display("gradient_residual_tokenizer_unit: match");
      end else begin
         $display("gradient_residual_tokenizer_unit: mismatch");
      end
      $finish;
   end

endmodule
